// ----- sv/pdift_pkg.sv -----
// pdift_pkg: shared types and constants of the serial frame transceiver.
// Used by the channel interfaces and by pdi_frame_transceiver.
`default_nettype none

package pdift_pkg;

   // frame layout and limits
   localparam int FRAME_BITS = 12;
   localparam int IDLE_MAX   = 64;
   localparam int LEFT_W     = 7;
   localparam logic [6:0] HUNT_RESET = 7'd64;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 7;
   localparam int KIND_W   = 3;

   // receiver phases: hunting, data bits 1..8, parity, first stop, second stop
   localparam logic [3:0] PH_HUNT      = 4'd0;
   localparam logic [3:0] PH_DATA_LAST = 4'd8;
   localparam logic [3:0] PH_PARITY    = 4'd9;
   localparam logic [3:0] PH_STOP1     = 4'd10;
   localparam logic [3:0] PH_STOP2     = 4'd11;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_HUNT_LIMIT = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TX   = 2'd0,
      OP_RX   = 2'd1,
      OP_IDLE = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LINE    = 3'd0,
      KIND_OK      = 3'd1,
      KIND_PARITY  = 3'd2,
      KIND_FRAMING = 3'd3,
      KIND_TIMEOUT = 3'd4
   } kind_type;

endpackage

`default_nettype wire

// ----- sv/pdift_if.sv -----
// pdift_req_if / pdift_rsp_if: valid/ready channels of the transceiver.
// Depends on pdift_pkg for field widths.
`default_nettype none

interface pdift_req_if import pdift_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [DATA_W-1:0]   tx_data;
   logic                sampled_bit;
   logic [COUNT_W-1:0]  idle_count;

   modport source (output valid, opcode, tx_data, sampled_bit, idle_count, input ready);
   modport sink   (input valid, opcode, tx_data, sampled_bit, idle_count, output ready);
endinterface

interface pdift_rsp_if import pdift_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              line_bit;
   logic [DATA_W-1:0] rx_byte;
   logic              last;

   modport source (output valid, kind, line_bit, rx_byte, last, input ready);
   modport sink   (input valid, kind, line_bit, rx_byte, last, output ready);
endinterface

`default_nettype wire

// ----- sv/pdi_frame_transceiver.sv -----
// pdi_frame_transceiver: 12-bit serial frame transmitter/receiver (8E2).
// Depends on pdift_pkg and the channel interfaces in pdift_if.sv.
//
//   channel  direction  word
//   req      in         opcode, tx_data, sampled_bit, idle_count
//   rsp      out        kind, line_bit, rx_byte, last
//   csr      APB        hunt_limit at byte address 0
//
// A receive word is taken every cycle unless rsp.ready stalls, and gives at
// most one result word. A transmit word gives 12 result words, an idle word
// n words; the result register sends one word per cycle while rsp.ready is
// high, so req is held until the final result word of the job moves out.
// Reset (synchronous) clears the receiver, empties both stages and sets
// hunt_limit to 64. rsp.ready low holds the result register and the job.
`default_nettype none

module pdi_frame_transceiver import pdift_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pdift_req_if.sink                  req,
   pdift_rsp_if.source                rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   // configuration
   logic [6:0] hunt_limit_ff, hunt_limit_in;

   // receiver state
   logic [3:0] rx_phase_ff, rx_phase_in;
   logic [6:0] hunt_count_ff, hunt_count_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic       parity_acc_ff, parity_acc_in;
   logic       parity_seen_ff, parity_seen_in;
   logic       stop_seen_ff, stop_seen_in;

   // job stage: results still to send for the current word
   logic [LEFT_W-1:0]     job_left_ff, job_left_in;
   logic [FRAME_BITS-1:0] job_bits_ff, job_bits_in;
   logic [KIND_W-1:0]     job_kind_ff, job_kind_in;
   logic [DATA_W-1:0]     job_byte_ff, job_byte_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic [DATA_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic job_valid, out_free, emit, job_done, accept;
   logic csr_write;

   // receive decode
   logic              rx_hit;
   logic [KIND_W-1:0] rx_kind;
   logic [DATA_W-1:0] rx_byte;
   logic [6:0]        lim;
   logic [7:0]        cnt;
   logic              frame_par;
   logic [LEFT_W-1:0] idle_sat;

   // handshake
   assign job_valid = (job_left_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign emit      = job_valid && out_free;
   assign job_done  = emit && (job_left_ff == LEFT_W'(1));
   assign req.ready = !job_valid || job_done;
   assign accept    = req.valid && req.ready;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_HUNT_LIMIT) ? {25'd0, hunt_limit_ff} : 32'd0;

   always_comb begin
      hunt_limit_in = hunt_limit_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_HUNT_LIMIT)) begin
         hunt_limit_in = csr_pwdata[6:0];
      end
   end

   assign frame_par = ^req.tx_data;
   assign idle_sat  = (req.idle_count > LEFT_W'(IDLE_MAX)) ? LEFT_W'(IDLE_MAX) : req.idle_count;
   assign lim       = (hunt_limit_ff == 7'd0) ? 7'd1 : hunt_limit_ff;
   assign cnt       = {1'b0, hunt_count_ff} + 8'd1;

   // receiver and word decode
   always_comb begin
      rx_phase_in    = rx_phase_ff;
      hunt_count_in  = hunt_count_ff;
      rx_shift_in    = rx_shift_ff;
      parity_acc_in  = parity_acc_ff;
      parity_seen_in = parity_seen_ff;
      stop_seen_in   = stop_seen_ff;
      rx_hit         = 1'b0;
      rx_kind        = KIND_TIMEOUT;
      rx_byte        = '0;
      if (accept) begin
         unique case (req.opcode)
            OP_TX, OP_IDLE: begin
               rx_phase_in    = PH_HUNT;
               hunt_count_in  = '0;
               rx_shift_in    = '0;
               parity_acc_in  = 1'b0;
               parity_seen_in = 1'b0;
               stop_seen_in   = 1'b0;
            end
            OP_RX: begin
               priority if (rx_phase_ff == PH_HUNT || rx_phase_ff > PH_STOP2) begin
                  if (!req.sampled_bit) begin
                     // start bit
                     rx_phase_in    = 4'd1;
                     hunt_count_in  = '0;
                     rx_shift_in    = '0;
                     parity_acc_in  = 1'b0;
                     parity_seen_in = 1'b0;
                     stop_seen_in   = 1'b0;
                  end else begin
                     rx_phase_in = PH_HUNT;
                     if (cnt >= {1'b0, lim}) begin
                        hunt_count_in = '0;
                        rx_hit        = 1'b1;
                        rx_kind       = KIND_TIMEOUT;
                     end else begin
                        hunt_count_in = cnt[6:0];
                     end
                  end
               end else if (rx_phase_ff <= PH_DATA_LAST) begin
                  rx_shift_in   = {req.sampled_bit, rx_shift_ff[7:1]};
                  parity_acc_in = parity_acc_ff ^ req.sampled_bit;
                  rx_phase_in   = rx_phase_ff + 4'd1;
               end else if (rx_phase_ff == PH_PARITY) begin
                  parity_seen_in = req.sampled_bit;
                  rx_phase_in    = PH_STOP1;
               end else if (rx_phase_ff == PH_STOP1) begin
                  stop_seen_in = req.sampled_bit;
                  rx_phase_in  = PH_STOP2;
               end else begin
                  // second stop: report the frame, level ignored
                  rx_hit  = 1'b1;
                  rx_byte = rx_shift_ff;
                  priority if (parity_seen_ff != parity_acc_ff) rx_kind = KIND_PARITY;
                  else if (!stop_seen_ff)                      rx_kind = KIND_FRAMING;
                  else                                         rx_kind = KIND_OK;
                  rx_phase_in    = PH_HUNT;
                  hunt_count_in  = '0;
                  rx_shift_in    = '0;
                  parity_acc_in  = 1'b0;
                  parity_seen_in = 1'b0;
                  stop_seen_in   = 1'b0;
               end
            end
            OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // job stage: load a new word, else shift out one result per emit
   always_comb begin
      job_left_in = job_left_ff;
      job_bits_in = job_bits_ff;
      job_kind_in = job_kind_ff;
      job_byte_in = job_byte_ff;
      if (emit) begin
         job_left_in = job_left_ff - LEFT_W'(1);
         job_bits_in = {1'b1, job_bits_ff[FRAME_BITS-1:1]};
      end
      if (accept) begin
         unique case (req.opcode)
            OP_TX: begin
               job_left_in = LEFT_W'(FRAME_BITS);
               job_bits_in = {2'b11, frame_par, req.tx_data, 1'b0};
               job_kind_in = KIND_LINE;
               job_byte_in = '0;
            end
            OP_IDLE: begin
               job_left_in = idle_sat;
               job_bits_in = '1;
               job_kind_in = KIND_LINE;
               job_byte_in = '0;
            end
            OP_RX: begin
               job_left_in = rx_hit ? LEFT_W'(1) : '0;
               job_bits_in = '0;
               job_kind_in = rx_kind;
               job_byte_in = rx_byte;
            end
            OP_NONE: begin
               job_left_in = '0;
            end
            default: begin
               job_left_in = '0;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = job_kind_ff;
         rsp_bit_in   = job_bits_ff[0];
         rsp_byte_in  = job_byte_ff;
         rsp_last_in  = (job_left_ff == LEFT_W'(1));
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.line_bit = rsp_bit_ff;
   assign rsp.rx_byte  = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_limit_ff  <= HUNT_RESET;
         rx_phase_ff    <= PH_HUNT;
         hunt_count_ff  <= '0;
         rx_shift_ff    <= '0;
         parity_acc_ff  <= 1'b0;
         parity_seen_ff <= 1'b0;
         stop_seen_ff   <= 1'b0;
         job_left_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hunt_limit_ff  <= hunt_limit_in;
         rx_phase_ff    <= rx_phase_in;
         hunt_count_ff  <= hunt_count_in;
         rx_shift_ff    <= rx_shift_in;
         parity_acc_ff  <= parity_acc_in;
         parity_seen_ff <= parity_seen_in;
         stop_seen_ff   <= stop_seen_in;
         job_left_ff    <= job_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      job_bits_ff <= job_bits_in;
      job_kind_ff <= job_kind_in;
      job_byte_ff <= job_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ----- tb/tb_pdi_frame_transceiver.sv -----
// tb_pdi_frame_transceiver: self-checking bench for the 8E2 serial frame transceiver.
// Depends on pdift_pkg, the channel interfaces in pdift_if.sv and pdi_frame_transceiver.
// A predictor in the scoreboard class computes the line and receive words that each request owes.
`default_nettype none

module tb_pdi_frame_transceiver;
   import pdift_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_WORDS    = 68;
   localparam int IDLE_PERCENT   = 34;
   localparam logic [CSR_ADDR_W-1:0] HUNT_LIMIT_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_IDX_HUNT_LIMIT));

   typedef struct packed {
      opcode_type         opcode;
      logic [DATA_W-1:0]  tx_data;
      logic               sampled_bit;
      logic [COUNT_W-1:0] idle_count;
   } xcvr_request_type;

   typedef struct packed {
      kind_type          kind;
      logic              line_bit;
      logic [DATA_W-1:0] rx_byte;
      logic              last;
   } xcvr_result_type;

   // predictor of line and receive words, plus the queue of words still owed
   class xcvr_scoreboard_type;
      logic [COUNT_W-1:0] hunt_limit;
      logic [3:0]         rx_phase;
      logic [COUNT_W-1:0] hunt_count;
      logic [DATA_W-1:0]  rx_shift;
      logic               parity_acc;
      logic               parity_seen;
      logic               stop_seen;
      xcvr_result_type    results_due[$];
      int                 errors;
      int                 checked;

      function new();
         hunt_limit = HUNT_RESET;
         errors     = 0;
         checked    = 0;
         clear_receiver();
      endfunction

      function void clear_receiver();
         rx_phase    = PH_HUNT;
         hunt_count  = '0;
         rx_shift    = '0;
         parity_acc  = 1'b0;
         parity_seen = 1'b0;
         stop_seen   = 1'b0;
      endfunction

      function void owe(kind_type k, logic lb, logic [DATA_W-1:0] d, logic l);
         xcvr_result_type r;
         r.kind     = k;
         r.line_bit = lb;
         r.rx_byte  = d;
         r.last     = l;
         results_due.push_back(r);
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // receiver: hunt for start, then 8 data, parity, stop1, stop2
      function void sample_line(logic b);
         int       lim;
         int       cnt;
         kind_type k;
         logic [DATA_W-1:0] got_byte;
         if (rx_phase == PH_HUNT || rx_phase > PH_STOP2) begin
            if (!b) begin
               clear_receiver();
               rx_phase = PH_HUNT + 4'd1;
            end else begin
               lim = (hunt_limit == '0) ? 1 : int'(hunt_limit);
               cnt = int'(hunt_count) + 1;
               rx_phase = PH_HUNT;
               if (cnt >= lim) begin
                  hunt_count = '0;
                  owe(KIND_TIMEOUT, 1'b0, '0, 1'b1);
               end else begin
                  hunt_count = COUNT_W'(cnt);
               end
            end
         end else if (rx_phase <= PH_DATA_LAST) begin
            rx_shift   = {b, rx_shift[DATA_W-1:1]};
            parity_acc = parity_acc ^ b;
            rx_phase   = rx_phase + 4'd1;
         end else if (rx_phase == PH_PARITY) begin
            parity_seen = b;
            rx_phase    = PH_STOP1;
         end else if (rx_phase == PH_STOP1) begin
            stop_seen = b;
            rx_phase  = PH_STOP2;
         end else begin
            // second stop: level ignored, parity error wins over framing
            if (parity_seen != parity_acc)
               k = KIND_PARITY;
            else if (!stop_seen)
               k = KIND_FRAMING;
            else
               k = KIND_OK;
            got_byte = rx_shift;
            clear_receiver();
            owe(k, 1'b0, got_byte, 1'b1);
         end
      endfunction

      // accepted request word: queue every result word it causes
      function void note_request(xcvr_request_type w);
         int n;
         case (w.opcode)
            OP_TX: begin
               clear_receiver();
               owe(KIND_LINE, 1'b0, '0, 1'b0);
               for (int i = 0; i < DATA_W; i++)
                  owe(KIND_LINE, w.tx_data[i], '0, 1'b0);
               owe(KIND_LINE, ^w.tx_data, '0, 1'b0);
               owe(KIND_LINE, 1'b1, '0, 1'b0);
               owe(KIND_LINE, 1'b1, '0, 1'b1);
            end
            OP_IDLE: begin
               clear_receiver();
               n = (w.idle_count > IDLE_MAX) ? IDLE_MAX : int'(w.idle_count);
               for (int i = 0; i < n; i++)
                  owe(KIND_LINE, 1'b1, '0, (i == n - 1));
            end
            OP_RX: sample_line(w.sampled_bit);
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(xcvr_result_type got);
         xcvr_result_type want;
         checked++;
         if (results_due.size() == 0) begin
            report($sformatf("word %0d: kind %0d arrived with nothing due", checked, got.kind));
            return;
         end
         want = results_due.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("word %0d: kind %0d, want %0d", checked, got.kind, want.kind));
         if (got.line_bit !== want.line_bit)
            report($sformatf("word %0d: line_bit %b, want %b", checked, got.line_bit,
                             want.line_bit));
         if (got.rx_byte !== want.rx_byte)
            report($sformatf("word %0d: rx_byte %h, want %h", checked, got.rx_byte,
                             want.rx_byte));
         if (got.last !== want.last)
            report($sformatf("word %0d: last %b, want %b", checked, got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   pdift_req_if req_ch ();
   pdift_rsp_if rsp_ch ();

   xcvr_scoreboard_type frames;
   xcvr_result_type     rsp_seen;
   int                  words_sent;
   int                  rsp_hold_cycles;
   logic                steady;
   int unsigned         cycle_count;

   pdi_frame_transceiver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, long hold-off on request, none when steady
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen.kind     = kind_type'(rsp_ch.kind);
         rsp_seen.line_bit = rsp_ch.line_bit;
         rsp_seen.rx_byte  = rsp_ch.rx_byte;
         rsp_seen.last     = rsp_ch.last;
         frames.check_result(rsp_seen);
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic xcvr_request_type make_word(opcode_type op);
      xcvr_request_type w;
      w.opcode      = op;
      w.tx_data     = DATA_W'($urandom);
      w.sampled_bit = 1'($urandom);
      w.idle_count  = COUNT_W'($urandom);
      return w;
   endfunction

   // offer one request word, with random gaps ahead of it
   task automatic drive_word(xcvr_request_type w);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= w.opcode;
      req_ch.tx_data     <= w.tx_data;
      req_ch.sampled_bit <= w.sampled_bit;
      req_ch.idle_count  <= w.idle_count;
      do @(posedge clock); while (!req_ch.ready);
      frames.note_request(w);
      if (w.opcode != OP_NONE)
         words_sent++;
   endtask

   task automatic send_rx(logic b);
      xcvr_request_type w;
      w = make_word(OP_RX);
      w.sampled_bit = b;
      drive_word(w);
   endtask

   task automatic send_tx(logic [DATA_W-1:0] d);
      xcvr_request_type w;
      w = make_word(OP_TX);
      w.tx_data = d;
      drive_word(w);
   endtask

   task automatic send_idle(logic [COUNT_W-1:0] n);
      xcvr_request_type w;
      w = make_word(OP_IDLE);
      w.idle_count = n;
      drive_word(w);
   endtask

   // receive frame sample by sample; cut < 12 leaves it unfinished
   task automatic send_frame(logic [DATA_W-1:0] d, logic bad_parity, logic bad_stop, int cut);
      logic [FRAME_BITS-1:0] line;
      line = {1'($urandom), ~bad_stop, (^d) ^ bad_parity, d, 1'b0};
      for (int i = 0; i < cut; i++)
         send_rx(line[i]);
   endtask

   // drop valid and wait until every owed word has come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (frames.pending() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receive samples carry no result, so let the block settle before the write
   task automatic set_hunt_limit(logic [COUNT_W-1:0] lim);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(HUNT_LIMIT_ADDR, {25'($urandom), lim});
      frames.hunt_limit = lim;
   endtask

   // mostly well-formed receive frames, with tx, idle, timeout runs and noise
   task automatic random_traffic(int goal);
      int pick;
      int eff;
      int len;
      while (words_sent < goal) begin
         pick = $urandom_range(99);
         eff  = (frames.hunt_limit == '0) ? 1 : int'(frames.hunt_limit);
         if (pick < 45) begin
            send_frame(DATA_W'($urandom), $urandom_range(6) == 0, $urandom_range(6) == 0,
                       ($urandom_range(9) == 0) ? $urandom_range(1, FRAME_BITS - 1)
                                                : FRAME_BITS);
         end else if (pick < 60) begin
            len = ($urandom_range(3) == 0) ? eff + 1 : $urandom_range(1, (eff < 8) ? eff : 8);
            repeat (len) send_rx(1'b1);
         end else if (pick < 72) begin
            send_tx(DATA_W'($urandom));
         end else if (pick < 84) begin
            send_idle(($urandom_range(19) == 0) ? COUNT_W'($urandom_range(127))
                                                : COUNT_W'($urandom_range(1, 8)));
         end else if (pick < 96) begin
            send_rx(1'($urandom));
         end else begin
            drive_word(make_word(OP_NONE));
         end
      end
   endtask

   initial begin
      frames          = new();
      words_sent      = 0;
      rsp_hold_cycles = 0;
      steady          = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_NONE;
      req_ch.tx_data     <= '0;
      req_ch.sampled_bit <= 1'b0;
      req_ch.idle_count  <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, idle counts incl. zero and saturation, unused opcode
      send_tx(8'h00);
      send_tx(8'hFF);
      send_tx(8'h5A);
      send_idle(7'd0);
      send_idle(7'd1);
      send_idle(7'd127);
      send_idle(7'd64);
      drive_word(make_word(OP_NONE));
      send_frame(8'hA5, 1'b0, 1'b0, FRAME_BITS);
      // zero hunt limit acts as one
      set_hunt_limit(7'd0);
      send_rx(1'b1);
      drive_word(make_word(OP_NONE));
      send_rx(1'b1);

      // random phases across hunt limits
      words_sent = 0;
      set_hunt_limit(7'd1);
      random_traffic(PHASE_WORDS);
      set_hunt_limit(7'd127);
      random_traffic(2 * PHASE_WORDS);

      // steady stretch: neither side idles
      set_hunt_limit(7'd3);
      steady = 1'b1;
      random_traffic(3 * PHASE_WORDS);
      wait_drained();
      steady = 1'b0;

      // receiver holds off while transmit words pile up
      set_hunt_limit(COUNT_W'($urandom_range(2, 20)));
      rsp_hold_cycles = 200;
      repeat (15) send_tx(DATA_W'($urandom));
      wait_drained();
      random_traffic(4 * PHASE_WORDS);

      set_hunt_limit(7'd0);
      random_traffic(5 * PHASE_WORDS);
      set_hunt_limit(7'd64);
      random_traffic(6 * PHASE_WORDS);
      set_hunt_limit(COUNT_W'($urandom_range(1, 127)));
      random_traffic(7 * PHASE_WORDS);

      // drain and let the block settle
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frames.pending() != 0)
         frames.report($sformatf("%0d result words never arrived", frames.pending()));
      if (frames.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
